>>> sv/fpmte_pkg.sv
// Package: shared types and constants for the fixed-point matrix transform engine.
`default_nettype none
package fpmte_pkg;

	localparam int unsigned FRAC_BITS = 14;
	localparam logic [31:0] Q_ONE = 32'h1 << FRAC_BITS;

	localparam logic [2:0] OP_WR_CUR   = 3'd0;
	localparam logic [2:0] OP_WR_OPD   = 3'd1;
	localparam logic [2:0] OP_MUL      = 3'd2;
	localparam logic [2:0] OP_IDENT    = 3'd3;
	localparam logic [2:0] OP_TRANS    = 3'd4;
	localparam logic [2:0] OP_XFORM    = 3'd5;
	localparam logic [2:0] OP_XFORM_NT = 3'd6;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] value;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic               last_in;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               last_out;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_MUL_RUN,
		ST_MUL_DRAIN,
		ST_MUL_WB,
		ST_XF_RUN,
		ST_XF_DRAIN
	} state_t;

	// Per-step control that travels down the multiply-accumulate pipe.
	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic       fin;
		logic       xf;
		logic [1:0] col;
	} ctl_t;

endpackage
`default_nettype wire

>>> sv/fixed_point_matrix_transform_engine_core.sv
// Top level: matrix stores, shared 32x32 multiply-accumulate unit and its sequencer.
// Element writes (ops 0, 1) and op 7 leave the sequencer idle; busy never rises.
// Transform (ops 5, 6): 12 steps on the shared multiplier, then the pipe drains; done pulses
//   once the final step has left the pipe, and the next start is taken after it has drained.
// Identity and translation load: all 16 entries, one matrix entry per write-port cycle.
// Concatenation: 4 rows of 16 MAC steps, a pipe drain and 4 write-backs of the row buffer.
// arst_n clears the sequencer and the result strobe; matrix contents stay unknown until written.
`default_nettype none
module fixed_point_matrix_transform_engine_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire fpmte_pkg::cmd_t  cmd,
	output logic                  done,
	output fpmte_pkg::res_t       result
);
	import fpmte_pkg::*;

	state_t state_q, state_d;
	logic [3:0] cnt_q;
	logic [1:0] row_q;
	cmd_t item_q;
	res_t res_q;
	logic done_q;

	logic [31:0] cur_mem [16];
	logic [31:0] opd_mem [16];
	logic [31:0] rowbuf_q [4];

	logic        accept;
	logic        cur_we;
	logic [3:0]  cur_waddr;
	logic [31:0] cur_wdata;
	logic [3:0]  cur_raddr;
	logic [3:0]  opd_raddr;
	logic [31:0] coord_sel;
	ctl_t        ctl_s0;

	logic [31:0]        a_s1;
	logic [31:0]        a_op;
	logic [31:0]        opd_rd_s1;
	logic [31:0]        coord_s1;
	ctl_t               ctl_s1;
	logic signed [63:0] prod_s2;
	ctl_t               ctl_s2;
	logic [31:0]        acc_q;

	logic signed [31:0] b_sel;
	logic [31:0]        term;
	logic [31:0]        sum;

	function automatic logic [31:0] pick_coord(input cmd_t c, input logic [1:0] idx);
		logic [31:0] v;
		case (idx)
			2'd0: v = c.coord_x;
			2'd1: v = c.coord_y;
			2'd2: v = c.coord_z;
			default: v = (c.op == OP_XFORM) ? 32'h1 : 32'h0;
		endcase
		return v;
	endfunction

	assign accept = start && (state_q == ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_MUL: state_d = ST_MUL_RUN;
						OP_IDENT, OP_TRANS: state_d = ST_FILL;
						OP_XFORM, OP_XFORM_NT: state_d = ST_XF_RUN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: if (cnt_q == 4'd15) state_d = ST_IDLE;
			ST_MUL_RUN: if (cnt_q == 4'd15) state_d = ST_MUL_DRAIN;
			ST_MUL_DRAIN: if (!ctl_s1.valid && !ctl_s2.valid) state_d = ST_MUL_WB;
			ST_MUL_WB: begin
				if (cnt_q[1:0] == 2'd3) state_d = (row_q == 2'd3) ? ST_IDLE : ST_MUL_RUN;
			end
			ST_XF_RUN: if (cnt_q == 4'd11) state_d = ST_XF_DRAIN;
			ST_XF_DRAIN: if (!ctl_s1.valid && !ctl_s2.valid) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: addresses, write port and step control
	always_comb begin
		busy      = (state_q != ST_IDLE);
		cur_we    = 1'b0;
		cur_waddr = cnt_q;
		cur_wdata = '0;
		cur_raddr = {row_q, cnt_q[1:0]};
		opd_raddr = {cnt_q[1:0], cnt_q[3:2]};
		coord_sel = pick_coord(item_q, cnt_q[1:0]);
		ctl_s0    = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.op == OP_WR_CUR) begin
					cur_we    = 1'b1;
					cur_waddr = {cmd.row, cmd.col};
					cur_wdata = cmd.value;
				end
			end
			ST_FILL: begin
				cur_we = 1'b1;
				if (cnt_q[3:2] == cnt_q[1:0]) begin
					cur_wdata = Q_ONE;
				end else if (item_q.op == OP_TRANS && cnt_q[3:2] == 2'd3) begin
					cur_wdata = coord_sel << FRAC_BITS;
				end
			end
			ST_MUL_RUN: begin
				ctl_s0.valid = 1'b1;
				ctl_s0.first = (cnt_q[1:0] == 2'd0);
				ctl_s0.last  = (cnt_q[1:0] == 2'd3);
				ctl_s0.col   = cnt_q[3:2];
			end
			ST_MUL_WB: begin
				cur_we    = 1'b1;
				cur_waddr = {row_q, cnt_q[1:0]};
				cur_wdata = rowbuf_q[cnt_q[1:0]];
			end
			ST_XF_RUN: begin
				// step: column in the upper bits, matrix row (x, y, z, translation) in the lower
				cur_raddr    = {cnt_q[1:0], cnt_q[3:2]};
				ctl_s0.valid = 1'b1;
				ctl_s0.xf    = 1'b1;
				ctl_s0.first = (cnt_q[1:0] == 2'd0);
				ctl_s0.last  = (cnt_q[1:0] == 2'd3);
				ctl_s0.fin   = (cnt_q == 4'd11);
				ctl_s0.col   = cnt_q[3:2];
			end
			default: begin
				ctl_s0 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			row_q   <= '0;
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 4'd0 : cnt_q + 4'd1;
			if (accept) begin
				row_q <= '0;
			end else if (state_q == ST_MUL_WB && cnt_q[1:0] == 2'd3) begin
				row_q <= row_q + 2'd1;
			end
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.fin;
		end
	end

	// Matrix stores
	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
		a_s1 <= cur_mem[cur_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.op == OP_WR_OPD) opd_mem[{cmd.row, cmd.col}] <= cmd.value;
		opd_rd_s1 <= opd_mem[opd_raddr];
	end

	// Drop the translation row entirely when the transform skips it
	assign a_op  = (ctl_s1.xf && ctl_s1.last && item_q.op == OP_XFORM_NT) ? 32'h0 : a_s1;
	assign b_sel = ctl_s1.xf ? coord_s1 : opd_rd_s1;
	assign term  = ctl_s2.xf ? prod_s2[31:0] : prod_s2[FRAC_BITS +: 32];
	assign sum   = (ctl_s2.first ? 32'h0 : acc_q) + term;

	always_ff @(posedge clk) begin
		if (accept) item_q <= cmd;
		if (accept) res_q.last_out <= cmd.last_in;
		coord_s1 <= coord_sel;
		prod_s2  <= $signed(a_op) * b_sel;
		if (ctl_s2.valid) acc_q <= sum;
		if (ctl_s2.valid && ctl_s2.last) begin
			if (ctl_s2.xf) begin
				case (ctl_s2.col)
					2'd0: res_q.out_x <= $signed(sum) >>> FRAC_BITS;
					2'd1: res_q.out_y <= $signed(sum) >>> FRAC_BITS;
					default: res_q.out_z <= $signed(sum) >>> FRAC_BITS;
				endcase
			end else begin
				rowbuf_q[ctl_s2.col] <= sum;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

>>> sv/fpmte_checker.sv
// Checker: port-level properties of the transform engine, bound to the top level.
`default_nettype none
module fpmte_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire fpmte_pkg::cmd_t cmd,
	input wire logic            done
);
	import fpmte_pkg::*;

	// a result only closes a transform that is still in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("more than one result beat for one transform");

	a_xf_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.op == OP_XFORM || cmd.op == OP_XFORM_NT)) |=> busy)
		else $error("transform accepted without going busy");

	a_wr_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.op == OP_WR_CUR || cmd.op == OP_WR_OPD)) |=> (!busy && !done))
		else $error("element write did not complete in one cycle");

endmodule

bind fixed_point_matrix_transform_engine_core fpmte_checker u_fpmte_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done)
);
`default_nettype wire
